### hw/rtl/ffba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Store geometry, field widths, result codes and the controller interface.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int BLOCK_TOTAL = 8;
  localparam int SIZE_BITS   = 16;

  // fixed widths of the word fields
  localparam int BIDX_W   = 3;
  localparam int AMOUNT_W = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;

  localparam int IDX_W = (BLOCK_TOTAL > 1) ? $clog2(BLOCK_TOTAL) : 1;
  localparam int CNT_W = $clog2(BLOCK_TOTAL + 1);
  localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

  localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = CFG_W'(8);

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NO_FIT    = 2'd2
  } status_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic scan_step;
    logic set_nofit;
    logic write;
    logic push;
  } ffba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic in_alloc;
    logic scan_end;
    logic scan_hit;
    logic out_free;
  } ffba_sts_t;

endpackage
`default_nettype wire

### hw/rtl/ffba_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_req_if: command channel
// Valid/ready channel carrying one load or allocate command per word.
// ----------------------------------------------------------------------------
interface ffba_req_if import ffba_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                command;
  logic [BIDX_W-1:0]   block_index;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, command, block_index, amount, input ready);
  modport sink   (input valid, command, block_index, amount, output ready);

endinterface
`default_nettype wire

### hw/rtl/ffba_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_rsp_if: result channel
// Valid/ready channel carrying one result word per command.
// ----------------------------------------------------------------------------
interface ffba_rsp_if import ffba_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BIDX_W-1:0]   chosen_block;
  logic [AMOUNT_W-1:0] space_left;

  modport source (output valid, status, chosen_block, space_left, input ready);
  modport sink   (input valid, status, chosen_block, space_left, output ready);

endinterface
`default_nettype wire

### hw/rtl/ffba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl: allocator sequencer
// Steps each command through capture, block scan (allocate only), write-back (skipped on no fit) and result.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ffba_sts_t sts,
  output ffba_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_next = sts.in_alloc ? S_SCAN : S_WRITE;
        end
      end
      S_SCAN: begin
        priority if (sts.scan_end) begin
          cmd.set_nofit = 1'b1;
          state_next    = S_RESULT;
        end else if (sts.scan_hit) begin
          state_next = S_WRITE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/ffba_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_dp: allocator datapath
// Free-space store, scan counter, one compare/subtract unit, output register.
// ----------------------------------------------------------------------------
module ffba_dp import ffba_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  ffba_req_if.sink              req,
  ffba_rsp_if.source            rsp,
  input  wire ffba_cmd_t        cmd,
  output ffba_sts_t             sts
);

  logic [SIZE_BITS-1:0] store [BLOCK_TOTAL];
  logic [CFG_W-1:0]     block_count;
  logic [CNT_W-1:0]     scan_cnt;

  logic                 cur_alloc;
  logic [BIDX_W-1:0]    cur_idx;
  logic [AMOUNT_W-1:0]  cur_amount;

  status_t              res_status;
  logic [BIDX_W-1:0]    res_block;
  logic [AMOUNT_W-1:0]  res_left;

  logic                 out_valid;
  status_t              out_status;
  logic [BIDX_W-1:0]    out_block;
  logic [AMOUNT_W-1:0]  out_left;

  logic                 capture;
  logic [CNT_W-1:0]     scan_limit;
  logic [IDX_W-1:0]     scan_idx;
  logic [SIZE_BITS-1:0] scan_free;
  logic                 scan_hit;
  logic [CMP_W-1:0]     diff;
  logic [SIZE_BITS-1:0] load_val;
  logic [SIZE_BITS-1:0] alloc_val;
  logic                 load_in_range;
  logic [IDX_W-1:0]     load_idx;

  assign capture = cmd.in_ready && req.valid;
  assign req.ready = cmd.in_ready;

  // counts above the store size scan the whole store
  assign scan_limit = (32'(block_count) > BLOCK_TOTAL) ? CNT_W'(BLOCK_TOTAL)
                                                       : CNT_W'(block_count);
  assign scan_idx   = scan_cnt[IDX_W-1:0];
  assign scan_free  = store[scan_idx];
  assign scan_hit   = CMP_W'(scan_free) >= CMP_W'(cur_amount);
  assign diff       = CMP_W'(scan_free) - CMP_W'(cur_amount);
  assign alloc_val  = diff[SIZE_BITS-1:0];
  assign load_val   = SIZE_BITS'(cur_amount);
  assign load_in_range = 32'(cur_idx) < BLOCK_TOTAL;
  assign load_idx   = IDX_W'(cur_idx);

  assign sts.in_valid = req.valid;
  assign sts.in_alloc = req.command == CMD_ALLOC;
  assign sts.scan_end = scan_cnt >= scan_limit;
  assign sts.scan_hit = scan_hit;
  assign sts.out_free = !out_valid || rsp.ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RST;
      out_valid   <= 1'b0;
      for (int i = 0; i < BLOCK_TOTAL; i++) begin
        store[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.write) begin
        if (cur_alloc) begin
          store[scan_idx] <= alloc_val;
        end else if (load_in_range) begin
          store[load_idx] <= load_val;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (capture) begin
      cur_alloc  <= req.command == CMD_ALLOC;
      cur_idx    <= req.block_index;
      cur_amount <= req.amount;
      scan_cnt   <= '0;
    end else if (cmd.scan_step) begin
      scan_cnt <= scan_cnt + CNT_W'(1);
    end
    if (cmd.set_nofit) begin
      res_status <= ST_NO_FIT;
      res_block  <= '0;
      res_left   <= '0;
    end else if (cmd.write) begin
      if (cur_alloc) begin
        res_status <= ST_ALLOCATED;
        res_block  <= BIDX_W'(scan_idx);
        res_left   <= AMOUNT_W'(alloc_val);
      end else begin
        res_status <= ST_LOADED;
        res_block  <= cur_idx;
        res_left   <= load_in_range ? AMOUNT_W'(load_val) : '0;
      end
    end
    if (cmd.push) begin
      out_status <= res_status;
      out_block  <= res_block;
      out_left   <= res_left;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.chosen_block = out_block;
  assign rsp.space_left   = out_left;

endmodule
`default_nettype wire

### hw/rtl/first_fit_block_allocator_unit.sv
`default_nettype none
// Load: accept, write-back, result. Allocate: accept, a scan of the blocks
// (one block per cycle through the single compare/subtract unit, at most
// min(block_count, 8) blocks), write-back on a fit, then result.
// One command in flight; the next is taken while a result word waits.
// Synchronous reset clears the free-space store to zero and sets
// block_count to 8.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit: first-fit block allocator
// Keeps free space per block; loads a block or allocates from the first fit.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit import ffba_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  ffba_req_if.sink              req,
  ffba_rsp_if.source            rsp
);

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  ffba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

### sim/first_fit_block_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit_tb: self-checking bench for the allocator
// Drives load and allocate commands, predicts each result word from a local
// copy of the free-space store and compares it with the word that comes back.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit_tb;
  import ffba_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 12;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 16;
  localparam int NUM_PHASES    = 12;

  typedef struct {
    command_t            cmd;
    logic [BIDX_W-1:0]   idx;
    logic [AMOUNT_W-1:0] amt;
  } cmd_word_t;

  typedef struct {
    status_t             st;
    logic [BIDX_W-1:0]   blk;
    logic [AMOUNT_W-1:0] left;
  } result_word_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  ffba_req_if req_if ();
  ffba_rsp_if rsp_if ();

  first_fit_block_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if.sink),
    .rsp       (rsp_if.source)
  );

  // local copy of the allocator state
  logic [SIZE_BITS-1:0] free_space [BLOCK_TOTAL] = '{default: '0};
  logic [CFG_W-1:0]     blk_count = BLOCK_COUNT_RST;

  cmd_word_t    pending_cmds [$];
  result_word_t expected_results [$];
  cmd_word_t    cur_cmd;

  int unsigned src_gap_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned src_gap = 0;
  int unsigned snk_stall = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_cnt = 0;

  int errors = 0;
  int n_results = 0;
  int n_loads = 0;
  int n_fits = 0;
  int n_nofit = 0;
  int n_cfg = 0;
  int stall_run = 0;
  int max_stall = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    req_if.valid       = 1'b0;
    req_if.command     = 1'b0;
    req_if.block_index = '0;
    req_if.amount      = '0;
    rsp_if.ready       = 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout: %0d results still expected", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // apply a load, or a first fit over the first min(block_count, BLOCK_TOTAL) blocks
  function automatic result_word_t first_fit_apply(cmd_word_t w);
    result_word_t r;
    int lim;
    int i;
    r.st   = ST_NO_FIT;
    r.blk  = '0;
    r.left = '0;
    if (w.cmd == CMD_LOAD) begin
      r.st  = ST_LOADED;
      r.blk = w.idx;
      if (w.idx < BLOCK_TOTAL) begin
        free_space[w.idx] = SIZE_BITS'(w.amt);
        r.left = AMOUNT_W'(free_space[w.idx]);
      end
      n_loads++;
    end else begin
      lim = (blk_count > BLOCK_TOTAL) ? BLOCK_TOTAL : int'(blk_count);
      for (i = 0; i < lim; i++) begin
        if (r.st == ST_NO_FIT && free_space[i] >= w.amt) begin
          free_space[i] = free_space[i] - SIZE_BITS'(w.amt);
          r.st   = ST_ALLOCATED;
          r.blk  = BIDX_W'(i);
          r.left = AMOUNT_W'(free_space[i]);
        end
      end
      if (r.st == ST_NO_FIT)
        n_nofit++;
      else
        n_fits++;
    end
    return r;
  endfunction

  // command driver
  always @(posedge clk) begin : cmd_driver
    if (rst) begin
      req_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready)
        expected_results.push_back(first_fit_apply(cur_cmd));
      if (req_if.valid && !req_if.ready) begin
        stall_run++;
        if (stall_run > max_stall)
          max_stall = stall_run;
      end else begin
        stall_run = 0;
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_gap == 0 && src_gap_pct != 0 && pending_cmds.size() != 0 &&
            $urandom_range(0, 99) < src_gap_pct)
          src_gap = $urandom_range(1, 12);
        if (src_gap != 0) begin
          src_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          req_if.valid       <= 1'b1;
          req_if.command     <= cur_cmd.cmd;
          req_if.block_index <= cur_cmd.idx;
          req_if.amount      <= cur_cmd.amt;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, so the block backs up into the command channel
  always @(posedge clk) begin
    if (rst)
      hold_cnt <= 0;
    else if (hold_go)
      hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt != 0)
      hold_cnt <= hold_cnt - 1;
  end

  // result monitor and checker
  always @(posedge clk) begin : result_monitor
    result_word_t got;
    result_word_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      snk_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.st   = status_t'(rsp_if.status);
        got.blk  = rsp_if.chosen_block;
        got.left = rsp_if.space_left;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word %0d: status %0d block %0d left %0d",
                     n_results, rsp_if.status, got.blk, got.left);
        end else begin
          want = expected_results.pop_front();
          if (got.st !== want.st || got.blk !== want.blk || got.left !== want.left) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch on word %0d: expected %s block %0d left %0d, ",
                        "got status %0d block %0d left %0d"},
                       n_results, want.st.name(), want.blk, want.left,
                       rsp_if.status, got.blk, got.left);
          end
        end
        n_results++;
      end
      if (hold_cnt != 0) begin
        rsp_if.ready <= 1'b0;
      end else begin
        if (snk_stall == 0 && snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct)
          snk_stall = $urandom_range(1, 12);
        if (snk_stall != 0) begin
          snk_stall--;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  task automatic add_cmd(command_t c, int idx, int amt);
    cmd_word_t w;
    w.cmd = c;
    w.idx = BIDX_W'(idx);
    w.amt = AMOUNT_W'(amt);
    pending_cmds.push_back(w);
  endtask

  function automatic cmd_word_t random_cmd();
    cmd_word_t w;
    int unsigned pick;
    w.idx = BIDX_W'($urandom_range(0, BLOCK_TOTAL - 1));
    pick  = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < 30) begin
      w.cmd = CMD_LOAD;
      if (pick < 4)      w.amt = AMOUNT_W'($urandom());
      else if (pick < 8) w.amt = AMOUNT_W'($urandom_range(0, 1023));
      else if (pick < 9) w.amt = '0;
      else               w.amt = '1;
    end else begin
      w.cmd = CMD_ALLOC;
      if (pick < 5)      w.amt = AMOUNT_W'($urandom_range(0, 255));
      else if (pick < 7) w.amt = AMOUNT_W'($urandom());
      else if (pick < 8) w.amt = '0;
      else if (pick < 9) w.amt = '1;
      else               w.amt = AMOUNT_W'($urandom_range(256, 4095));
    end
    return w;
  endfunction

  // wait until nothing is queued, offered or outstanding
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || req_if.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_count(int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    blk_count = CFG_W'(v);
    n_cfg++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int counts [NUM_PHASES];
    int p;
    int k;
    counts = '{8, 1, 15, 4, 9, 0, 3, 6, 2, 12, 7, 8};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset count of 8, store all zero
    add_cmd(CMD_ALLOC, 0, 0);           // zero request fits an empty block
    add_cmd(CMD_ALLOC, 0, 1);           // nothing fits yet
    add_cmd(CMD_LOAD, 7, 'hFFFF);
    add_cmd(CMD_LOAD, 0, 1);
    add_cmd(CMD_LOAD, 3, 'h8000);
    add_cmd(CMD_LOAD, 6, 0);
    add_cmd(CMD_ALLOC, 5, 'hFFFF);
    add_cmd(CMD_ALLOC, 0, 1);
    add_cmd(CMD_ALLOC, 0, 'h8000);
    add_cmd(CMD_LOAD, 2, 'h5555);
    add_cmd(CMD_LOAD, 4, 'hAAAA);
    add_cmd(CMD_ALLOC, 7, 'h5556);
    add_cmd(CMD_ALLOC, 0, 0);
    drain();

    // blocks past the count are written but never scanned
    write_block_count(2);
    add_cmd(CMD_LOAD, 5, 'hFFFF);
    add_cmd(CMD_ALLOC, 0, 'h10);
    add_cmd(CMD_LOAD, 1, 'h20);
    add_cmd(CMD_ALLOC, 0, 'h10);
    drain();

    // empty scan range
    write_block_count(0);
    add_cmd(CMD_ALLOC, 0, 0);
    add_cmd(CMD_LOAD, 0, 3);
    drain();

    // count above the block total scans all blocks
    write_block_count(15);
    add_cmd(CMD_ALLOC, 0, 'hFFF0);
    add_cmd(CMD_ALLOC, 0, 3);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_block_count(counts[p]);
      if (p >= NUM_PHASES - 2) begin
        src_gap_pct   = 0;
        snk_stall_pct = 0;
      end else begin
        src_gap_pct   = (p % 3 != 2) ? $urandom_range(5, 30) : 0;
        snk_stall_pct = (p % 3 != 1) ? $urandom_range(5, 30) : 0;
      end
      if (p == 3) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        @(negedge clk);
      end
      // load every block first so allocations get past the scan
      for (k = 0; k < BLOCK_TOTAL; k++)
        add_cmd(CMD_LOAD, k, $urandom_range(0, 2047));
      for (k = BLOCK_TOTAL; k < PHASE_ITEMS; k++)
        pending_cmds.push_back(random_cmd());
      drain();
    end

    errors += expected_results.size();
    $display({"Ran %0d commands: %0d loads, %0d first-fit hits, %0d no-fit words, ",
              "%0d block_count writes."},
             n_results, n_loads, n_fits, n_nofit, n_cfg);
    $display("Longest command stall %0d cycles under a %0d-cycle result hold-off.",
             max_stall, HOLD_CYCLES);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_req_if.sv
hw/rtl/ffba_rsp_if.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/ffba_dp.sv
hw/rtl/first_fit_block_allocator_unit.sv
sim/first_fit_block_allocator_unit_tb.sv
